// ----- rtl/keyframe_spline_path_unit_defines.svh -----
// Assertion macros shared by the keyframe spline path RTL.
// No dependencies; modules expect signals clk and arst_n in scope.
`ifndef KEYFRAME_SPLINE_PATH_UNIT_DEFINES_SVH
`define KEYFRAME_SPLINE_PATH_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define KSPU_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define KSPU_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// An antecedent that implies a consequent in the next cycle.
`define KSPU_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/kspu_pkg.sv -----
// Shared types, codes and helpers of the keyframe spline path unit.
// No dependencies.
package kspu_pkg;

	localparam int MAX_KEYS_DEF = 128;
	localparam int NCH = 9;
	localparam int ONE_Q16 = 65536;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_QUERY  = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2
	} status_t;

	typedef logic [NCH-1:0][31:0] chan_vec_t;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] frame;
		logic               linear;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] ang_x;
		logic signed [31:0] ang_y;
		logic signed [31:0] ang_z;
		logic signed [31:0] scl_x;
		logic signed [31:0] scl_y;
		logic signed [31:0] scl_z;
	} kspu_cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
		logic signed [31:0] out_pos_z;
		logic signed [31:0] out_ang_x;
		logic signed [31:0] out_ang_y;
		logic signed [31:0] out_ang_z;
		logic signed [31:0] out_scl_x;
		logic signed [31:0] out_scl_y;
		logic signed [31:0] out_scl_z;
		logic [7:0]         key_count;
	} kspu_rsp_t;

	// One stored key: frame, linear flag and the nine channels.
	typedef struct packed {
		logic signed [31:0] frame;
		logic               linear;
		chan_vec_t          ch;
	} key_row_t;

	// Classified operation handed from the front end to the back end.
	typedef struct packed {
		func_t              func;
		logic signed [31:0] frame;
		key_row_t           row;
	} op_t;

	function automatic chan_vec_t default_ch();
		chan_vec_t v;
		for (int c = 0; c < NCH; c++) begin
			v[c] = (c >= 6) ? 32'(ONE_Q16) : 32'd0;
		end
		return v;
	endfunction

	function automatic kspu_rsp_t pack_rsp(status_t st, chan_vec_t ch, logic [7:0] kc);
		kspu_rsp_t r;
		r.status    = st;
		r.out_pos_x = ch[0];
		r.out_pos_y = ch[1];
		r.out_pos_z = ch[2];
		r.out_ang_x = ch[3];
		r.out_ang_y = ch[4];
		r.out_ang_z = ch[5];
		r.out_scl_x = ch[6];
		r.out_scl_y = ch[7];
		r.out_scl_z = ch[8];
		r.key_count = kc;
		return r;
	endfunction

endpackage

// ----- rtl/kspu_front.sv -----
// Front end: takes command transactions, classifies them and registers the result.
// Depends on kspu_pkg.
module kspu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  kspu_pkg::kspu_cmd_t cmd,
	output logic             op_valid,
	input  logic             op_ready,
	output kspu_pkg::op_t    op
);
	import kspu_pkg::*;

	logic valid_s1;
	op_t  op_s1;
	op_t  op_d;

	// Queries clamp a negative frame to zero here, so the back end sees a ready key.
	always_comb begin
		op_d.func       = func_t'(cmd.func);
		op_d.frame      = cmd.frame;
		if (op_d.func == FUNC_QUERY && cmd.frame[31]) begin
			op_d.frame = 32'sd0;
		end
		op_d.row.frame  = cmd.frame;
		op_d.row.linear = cmd.linear;
		op_d.row.ch     = {cmd.scl_z, cmd.scl_y, cmd.scl_x, cmd.ang_z, cmd.ang_y,
			cmd.ang_x, cmd.pos_z, cmd.pos_y, cmd.pos_x};
	end

	assign cmd_ready = !valid_s1 || op_ready;
	assign op_valid  = valid_s1;
	assign op        = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			op_s1 <= op_d;
		end
	end

endmodule

// ----- rtl/kspu_queue.sv -----
// Short FIFO of classified operations between the front end and the back end.
// Depends on kspu_pkg.
module kspu_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  kspu_pkg::op_t wr_op,
	output logic          rd_valid,
	input  logic          rd_ready,
	output kspu_pkg::op_t rd_op
);
	import kspu_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);

	op_t            entry_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [FW-1:0]  fill_q;
	logic           push;
	logic           pop;

	assign wr_ready = (fill_q != FW'(QUEUE_DEPTH));
	assign rd_valid = (fill_q != '0);
	assign rd_op    = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_op;
		end
	end

endmodule

// ----- rtl/kspu_back.sv -----
// Back end: key table memory, search and shift sequencer, divider and spline datapath.
// Depends on kspu_pkg and keyframe_spline_path_unit_defines.svh.
`include "keyframe_spline_path_unit_defines.svh"
module kspu_back #(
	parameter int MAX_KEYS = kspu_pkg::MAX_KEYS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	output logic              op_ready,
	input  kspu_pkg::op_t     op,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output kspu_pkg::kspu_rsp_t rsp
);
	import kspu_pkg::*;

	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int KW = 37;
	localparam int MW = 57;

	typedef enum logic [4:0] {
		ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_SCAN_DONE, ST_INS_WR,
		ST_SHD_RD, ST_SHD_WR, ST_SHU_RD, ST_SHU_WR,
		ST_Q_LAST, ST_Q_ONE, ST_Q_K, ST_Q_P1, ST_Q_P3, ST_Q_P4,
		ST_T_INIT, ST_DIV, ST_SP_A, ST_SP_B, ST_SP_C, ST_SP_D, ST_SP_E, ST_Q_DONE
	} state_t;

	state_t           st_q;
	op_t              op_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    i_q;
	logic [CW-1:0]    j_q;
	logic             eq_q;
	logic             grow_q;
	logic [AW-1:0]    k_q;
	logic [AW-1:0]    k3_q;
	logic [AW-1:0]    k4_q;
	key_row_t         p1_q, p2_q, p3_q, p4_q;
	logic [16:0]      t_q;
	logic [32:0]      rem_q;
	logic [32:0]      d_q;
	logic [4:0]       div_cnt_q;
	logic [3:0]       ch_q;
	logic signed [KW-1:0] c1_q, c2_q, c3_q;
	logic signed [MW-1:0] m_q;
	chan_vec_t        res_ch_q;
	logic             rsp_valid_q;
	kspu_rsp_t        rsp_q;

	key_row_t         mem [MAX_KEYS];
	key_row_t         rdata_q;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [AW-1:0]    mem_raddr;
	key_row_t         mem_wdata;

	logic [CW-1:0]    nm1, ip1, jp1, jm1;
	logic [AW-1:0]    kk;
	logic [CW:0]      kp1, kp2;
	logic [AW-1:0]    k1_d, k3_d, k4_d;
	logic signed [KW-1:0] s1, s2, s3, s4;
	logic signed [KW-1:0] h_d;
	logic signed [KW+1:0] mul_a;
	logic signed [MW-1:0] prod;
	logic signed [MW-1:0] r_sum;
	logic signed [MW-18:0] v_d;
	logic [31:0]      sat_d;
	logic signed [32:0] dq, numq;
	logic [33:0]      rem2;

	function automatic logic [AW-1:0] nm1_of(logic [CW-1:0] x);
		logic [CW-1:0] y;
		y = x - 1'b1;
		return y[AW-1:0];
	endfunction

	assign nm1 = count_q - 1'b1;
	assign ip1 = i_q + 1'b1;
	assign jp1 = j_q + 1'b1;
	assign jm1 = j_q - 1'b1;
	assign kk  = (i_q == '0) ? '0 : nm1_of(i_q);

	// Neighbour selection; a linear key takes itself as the key before and its successor as the key after next.
	always_comb begin
		kp1  = {1'b0, CW'(k_q)} + 1'b1;
		kp2  = {1'b0, CW'(k_q)} + 2'd2;
		k1_d = (k_q != '0 && !rdata_q.linear) ? k_q - 1'b1 : k_q;
		if (kp1 < {1'b0, count_q}) begin
			k3_d = kp1[AW-1:0];
			if (rdata_q.linear) begin
				k4_d = kp1[AW-1:0];
			end else if (kp2 < {1'b0, count_q}) begin
				k4_d = kp2[AW-1:0];
			end else begin
				k4_d = nm1[AW-1:0];
			end
		end else begin
			k3_d = nm1[AW-1:0];
			k4_d = nm1[AW-1:0];
		end
	end

	// Memory port control follows the sequencer state.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = i_q[AW-1:0];
		mem_wdata = op_q.row;
		mem_raddr = i_q[AW-1:0];
		unique case (st_q)
			ST_IDLE:      mem_raddr = nm1[AW-1:0];
			ST_SCAN_DONE: mem_raddr = kk;
			ST_INS_WR:    mem_we = 1'b1;
			ST_SHD_RD, ST_SHU_RD: mem_raddr = j_q[AW-1:0];
			ST_SHD_WR: begin
				mem_we    = 1'b1;
				mem_waddr = jp1[AW-1:0];
				mem_wdata = rdata_q;
			end
			ST_SHU_WR: begin
				mem_we    = 1'b1;
				mem_waddr = jm1[AW-1:0];
				mem_wdata = rdata_q;
			end
			ST_Q_K:  mem_raddr = k1_d;
			ST_Q_P1: mem_raddr = k3_q;
			ST_Q_P3: mem_raddr = k4_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// Spline datapath: one multiplier shared by the three Horner steps.
	always_comb begin
		s1   = KW'(signed'(p1_q.ch[ch_q]));
		s2   = KW'(signed'(p2_q.ch[ch_q]));
		s3   = KW'(signed'(p3_q.ch[ch_q]));
		s4   = KW'(signed'(p4_q.ch[ch_q]));
		h_d  = KW'(m_q >>> 16);
		unique case (st_q)
			ST_SP_C: mul_a = (KW+2)'(c2_q) + (KW+2)'(h_d);
			ST_SP_D: mul_a = (KW+2)'(c1_q) + (KW+2)'(h_d);
			default: mul_a = (KW+2)'(c3_q);
		endcase
		prod  = MW'(mul_a) * MW'(signed'({1'b0, t_q}));
		r_sum = m_q + (MW'(s2) <<< 17) + MW'(ONE_Q16);
		v_d   = (MW-17)'(r_sum >>> 17);
		if (v_d > (MW-17)'(64'sh7FFFFFFF)) begin
			sat_d = 32'h7FFF_FFFF;
		end else if (v_d < -(MW-17)'(64'sh80000000)) begin
			sat_d = 32'h8000_0000;
		end else begin
			sat_d = v_d[31:0];
		end
		dq   = 33'(p3_q.frame) - 33'(p2_q.frame);
		numq = 33'(op_q.frame) - 33'(p2_q.frame);
		rem2 = {rem_q, 1'b0};
	end

	assign op_ready  = (st_q == ST_IDLE) && !rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (op_valid && !rsp_valid_q) begin
						op_q <= op;
						i_q  <= '0;
						eq_q <= 1'b0;
						unique case (op.func)
							FUNC_CLEAR: begin
								count_q     <= '0;
								rsp_q       <= pack_rsp(STAT_OK, '0, 8'd0);
								rsp_valid_q <= 1'b1;
							end
							FUNC_INSERT, FUNC_REMOVE: begin
								st_q <= (count_q == '0) ? ST_SCAN_DONE : ST_SCAN_RD;
							end
							FUNC_QUERY: begin
								if (count_q == '0) begin
									rsp_q       <= pack_rsp(STAT_OK, default_ch(), 8'd0);
									rsp_valid_q <= 1'b1;
								end else if (count_q == CW'(1)) begin
									st_q <= ST_Q_ONE;
								end else begin
									st_q <= ST_Q_LAST;
								end
							end
						endcase
					end
				end
				ST_SCAN_RD: st_q <= ST_SCAN_CHK;
				ST_SCAN_CHK: begin
					if (rdata_q.frame >= op_q.frame) begin
						eq_q <= (rdata_q.frame == op_q.frame);
						st_q <= ST_SCAN_DONE;
					end else begin
						i_q  <= ip1;
						st_q <= (ip1 == count_q) ? ST_SCAN_DONE : ST_SCAN_RD;
					end
				end
				ST_SCAN_DONE: begin
					unique case (op_q.func)
						FUNC_INSERT: begin
							if (eq_q) begin
								grow_q <= 1'b0;
								st_q   <= ST_INS_WR;
							end else if (count_q == CW'(MAX_KEYS)) begin
								rsp_q       <= pack_rsp(STAT_FULL, '0, 8'(count_q));
								rsp_valid_q <= 1'b1;
								st_q        <= ST_IDLE;
							end else begin
								grow_q <= 1'b1;
								j_q    <= nm1;
								st_q   <= (i_q == count_q) ? ST_INS_WR : ST_SHD_RD;
							end
						end
						FUNC_REMOVE: begin
							if (!eq_q) begin
								rsp_q       <= pack_rsp(STAT_NOT_FOUND, '0, 8'(count_q));
								rsp_valid_q <= 1'b1;
								st_q        <= ST_IDLE;
							end else if (ip1 == count_q) begin
								count_q     <= nm1;
								rsp_q       <= pack_rsp(STAT_OK, '0, 8'(nm1));
								rsp_valid_q <= 1'b1;
								st_q        <= ST_IDLE;
							end else begin
								j_q  <= ip1;
								st_q <= ST_SHU_RD;
							end
						end
						FUNC_QUERY: begin
							k_q  <= kk;
							st_q <= ST_Q_K;
						end
						FUNC_CLEAR: st_q <= ST_IDLE;
					endcase
				end
				ST_INS_WR: begin
					if (grow_q) begin
						count_q <= count_q + 1'b1;
						rsp_q   <= pack_rsp(STAT_OK, '0, 8'(count_q + 1'b1));
					end else begin
						rsp_q   <= pack_rsp(STAT_OK, '0, 8'(count_q));
					end
					rsp_valid_q <= 1'b1;
					st_q        <= ST_IDLE;
				end
				ST_SHD_RD: st_q <= ST_SHD_WR;
				ST_SHD_WR: begin
					if (j_q == i_q) begin
						st_q <= ST_INS_WR;
					end else begin
						j_q  <= jm1;
						st_q <= ST_SHD_RD;
					end
				end
				ST_SHU_RD: st_q <= ST_SHU_WR;
				ST_SHU_WR: begin
					if (j_q == nm1) begin
						count_q     <= nm1;
						rsp_q       <= pack_rsp(STAT_OK, '0, 8'(nm1));
						rsp_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end else begin
						j_q  <= jp1;
						st_q <= ST_SHU_RD;
					end
				end
				ST_Q_LAST: begin
					if (op_q.frame > rdata_q.frame) begin
						rsp_q       <= pack_rsp(STAT_OK, rdata_q.ch, 8'(count_q));
						rsp_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end else begin
						i_q  <= '0;
						st_q <= ST_SCAN_RD;
					end
				end
				ST_Q_ONE: begin
					rsp_q       <= pack_rsp(STAT_OK, rdata_q.ch, 8'(count_q));
					rsp_valid_q <= 1'b1;
					st_q        <= ST_IDLE;
				end
				ST_Q_K: begin
					p2_q <= rdata_q;
					k3_q <= k3_d;
					k4_q <= k4_d;
					st_q <= ST_Q_P1;
				end
				ST_Q_P1: begin
					p1_q <= rdata_q;
					st_q <= ST_Q_P3;
				end
				ST_Q_P3: begin
					p3_q <= rdata_q;
					st_q <= ST_Q_P4;
				end
				ST_Q_P4: begin
					p4_q <= rdata_q;
					st_q <= ST_T_INIT;
				end
				ST_T_INIT: begin
					ch_q <= '0;
					if (dq <= 33'sd0 || numq <= 33'sd0) begin
						t_q  <= '0;
						st_q <= ST_SP_A;
					end else if (numq >= dq) begin
						t_q  <= 17'(ONE_Q16);
						st_q <= ST_SP_A;
					end else begin
						t_q       <= '0;
						rem_q     <= numq;
						d_q       <= dq;
						div_cnt_q <= 5'd16;
						st_q      <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem2 >= {1'b0, d_q}) begin
						rem_q <= 33'(rem2 - {1'b0, d_q});
						t_q   <= {t_q[15:0], 1'b1};
					end else begin
						rem_q <= rem2[32:0];
						t_q   <= {t_q[15:0], 1'b0};
					end
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == 5'd1) begin
						st_q <= ST_SP_A;
					end
				end
				ST_SP_A: begin
					c1_q <= s3 - s1;
					c2_q <= (s1 <<< 1) - (s2 <<< 2) - s2 + (s3 <<< 2) - s4;
					c3_q <= s2 + (s2 <<< 1) - s3 - (s3 <<< 1) + s4 - s1;
					st_q <= ST_SP_B;
				end
				ST_SP_B: begin
					m_q  <= prod;
					st_q <= ST_SP_C;
				end
				ST_SP_C: begin
					m_q  <= prod;
					st_q <= ST_SP_D;
				end
				ST_SP_D: begin
					m_q  <= prod;
					st_q <= ST_SP_E;
				end
				ST_SP_E: begin
					res_ch_q[ch_q] <= sat_d;
					if (ch_q == 4'(NCH - 1)) begin
						st_q <= ST_Q_DONE;
					end else begin
						ch_q <= ch_q + 1'b1;
						st_q <= ST_SP_A;
					end
				end
				ST_Q_DONE: begin
					rsp_q       <= pack_rsp(STAT_OK, res_ch_q, 8'(count_q));
					rsp_valid_q <= 1'b1;
					st_q        <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`KSPU_CHECK(a_count_bound, count_q <= CW'(MAX_KEYS), "key count beyond table size")
	`KSPU_IMPLY(a_div_rem, st_q == ST_DIV, rem_q < d_q, "divider remainder not below divisor")
	`KSPU_NEXT(a_take_busy, op_valid && op_ready, st_q != ST_IDLE || rsp_valid_q, "operation taken but dropped")

endmodule

// ----- rtl/keyframe_spline_path_unit.sv -----
// Keyframe spline path unit: top level joining front end, queue and back end.
// Depends on kspu_pkg, kspu_front, kspu_queue and kspu_back.
//
// The unit keeps a table of up to MAX_KEYS keyframes sorted by frame, each holding a
// linear flag and nine Q16.16 channels, and answers one response transaction for every
// command transaction. Insert replaces a key at an equal frame or adds one at its sorted
// place, remove closes the gap, clear empties the table, and query evaluates a
// Catmull-Rom spline through four neighbouring keys. A front end registers and
// classifies each command and passes it through a two-entry queue, so that commands
// keep arriving while the back end works. The back end runs one command at a time
// through a key memory with one write port and a registered read port: an insert or
// remove scans keys and then moves them, and the keys scanned and moved together never
// exceed n + 1 for n stored keys. A query scans keys, fetches the four neighbours,
// derives the fraction in the bit-serial divider and evaluates the channels one after
// another in the shared multiplier. Clear and a query on an empty table answer straight
// from the idle state. The response sits in an output register until it is taken; the
// key memory needs no clearing after reset because only entries below the key count are
// ever used.
module keyframe_spline_path_unit #(
	parameter int MAX_KEYS = kspu_pkg::MAX_KEYS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  kspu_pkg::kspu_cmd_t cmd,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output kspu_pkg::kspu_rsp_t rsp
);
	import kspu_pkg::*;

	logic front_valid;
	logic front_ready;
	op_t  front_op;
	logic back_valid;
	logic back_ready;
	op_t  back_op;

	kspu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.op_valid  (front_valid),
		.op_ready  (front_ready),
		.op        (front_op)
	);

	// The queue lets the front end keep taking transactions while the back end is busy.
	kspu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_op    (front_op),
		.rd_valid (back_valid),
		.rd_ready (back_ready),
		.rd_op    (back_op)
	);

	kspu_back #(
		.MAX_KEYS (MAX_KEYS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (back_valid),
		.op_ready  (back_ready),
		.op        (back_op),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench of the keyframe spline path unit: keyframe table and spline queries.
// Depends on kspu_pkg and the top level keyframe_spline_path_unit.
// A scoreboard class keeps its own copy of the key table and predicts every response.
module tb;
	import kspu_pkg::*;

	localparam int TBL_KEYS = 128;
	localparam int CHANNELS = 9;
	localparam int STALL_LIMIT = 20000;

	// Scoreboard: its own sorted key table; each accepted command yields one predicted response.
	class path_scoreboard;
		int unsigned stored;
		logic signed [31:0] frames [TBL_KEYS];
		bit lin [TBL_KEYS];
		logic signed [31:0] chans [TBL_KEYS][CHANNELS];
		kspu_rsp_t pending [$];
		int unsigned mismatches;
		int unsigned checked;

		function new();
			stored = 0;
			mismatches = 0;
			checked = 0;
		endfunction

		static function longint floor_div_pow2(longint x, int s);
			return x >>> s;
		endfunction

		static function logic signed [31:0] clamp32(longint v);
			if (v > 64'sd2147483647) begin
				return 32'sh7fffffff;
			end
			if (v < -64'sd2147483648) begin
				return 32'sh80000000;
			end
			return v[31:0];
		endfunction

		static function logic signed [31:0] catmull(longint p1, longint p2, longint p3,
				longint p4, longint t);
			longint c1, c2, c3, h3, h2, r;
			c1 = p3 - p1;
			c2 = 2 * p1 - 5 * p2 + 4 * p3 - p4;
			c3 = -p1 + 3 * p2 - 3 * p3 + p4;
			h3 = floor_div_pow2(c3 * t, 16);
			h2 = floor_div_pow2((c2 + h3) * t, 16);
			r = (c1 + h2) * t + p2 * 2 * ONE_Q16 + ONE_Q16;
			return clamp32(floor_div_pow2(r, 17));
		endfunction

		function void evaluate(longint f, output logic signed [31:0] res [CHANNELS]);
			int k, k1, k3, k4, i;
			longint d, t, num;
			if (stored == 0) begin
				for (int c = 0; c < CHANNELS; c++) begin
					res[c] = (c >= 6) ? ONE_Q16 : 0;
				end
				return;
			end
			if (stored == 1) begin
				res = chans[0];
				return;
			end
			if (f < 0) begin
				f = 0;
			end
			if (f > frames[stored - 1]) begin
				res = chans[stored - 1];
				return;
			end
			if (f <= frames[0]) begin
				k = 0;
			end else begin
				i = 1;
				while (i < stored && frames[i] < f) begin
					i++;
				end
				k = i - 1;
			end
			k1 = (k > 0) ? k - 1 : k;
			if (lin[k]) begin
				k1 = k;
			end
			if (k + 1 < stored) begin
				k3 = k + 1;
				if (lin[k]) begin
					k4 = k3;
				end else begin
					k4 = (k + 2 < stored) ? k + 2 : stored - 1;
				end
			end else begin
				k3 = stored - 1;
				k4 = stored - 1;
			end
			d = longint'(frames[k3]) - longint'(frames[k]);
			t = 0;
			if (d > 0) begin
				num = f - longint'(frames[k]);
				if (num > 0) begin
					t = (num * ONE_Q16) / d;
					if (t > ONE_Q16) begin
						t = ONE_Q16;
					end
				end
			end
			for (int c = 0; c < CHANNELS; c++) begin
				res[c] = catmull(chans[k1][c], chans[k][c], chans[k3][c], chans[k4][c], t);
			end
		endfunction

		function int find_frame(logic signed [31:0] f);
			for (int i = 0; i < stored; i++) begin
				if (frames[i] == f) begin
					return i;
				end
			end
			return -1;
		endfunction

		// Apply an accepted command to the table and queue the response it must produce.
		function void note_command(kspu_cmd_t cmd);
			logic signed [31:0] res [CHANNELS];
			logic signed [31:0] val [CHANNELS];
			status_t st;
			int pos;
			kspu_rsp_t r;
			st = STAT_OK;
			for (int c = 0; c < CHANNELS; c++) begin
				res[c] = 0;
			end
			val = '{cmd.pos_x, cmd.pos_y, cmd.pos_z, cmd.ang_x, cmd.ang_y, cmd.ang_z,
				cmd.scl_x, cmd.scl_y, cmd.scl_z};
			case (func_t'(cmd.func))
				FUNC_INSERT: begin
					pos = find_frame(cmd.frame);
					if (pos < 0 && stored >= TBL_KEYS) begin
						st = STAT_FULL;
					end else begin
						if (pos < 0) begin
							pos = 0;
							while (pos < stored && frames[pos] < cmd.frame) begin
								pos++;
							end
							for (int i = stored; i > pos; i--) begin
								frames[i] = frames[i - 1];
								lin[i] = lin[i - 1];
								chans[i] = chans[i - 1];
							end
							stored++;
						end
						frames[pos] = cmd.frame;
						lin[pos] = cmd.linear;
						chans[pos] = val;
					end
				end
				FUNC_REMOVE: begin
					pos = find_frame(cmd.frame);
					if (pos < 0) begin
						st = STAT_NOT_FOUND;
					end else begin
						for (int i = pos; i < stored - 1; i++) begin
							frames[i] = frames[i + 1];
							lin[i] = lin[i + 1];
							chans[i] = chans[i + 1];
						end
						stored--;
					end
				end
				FUNC_QUERY: begin
					evaluate(longint'(cmd.frame), res);
				end
				default: begin
					stored = 0;
				end
			endcase
			r.status = st;
			r.out_pos_x = res[0];
			r.out_pos_y = res[1];
			r.out_pos_z = res[2];
			r.out_ang_x = res[3];
			r.out_ang_y = res[4];
			r.out_ang_z = res[5];
			r.out_scl_x = res[6];
			r.out_scl_y = res[7];
			r.out_scl_z = res[8];
			r.key_count = stored[7:0];
			pending.push_back(r);
		endfunction

		// Compare a response transaction with the oldest prediction, field by field.
		function void check_response(kspu_rsp_t got);
			kspu_rsp_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Unexpected response transaction: %p", got);
				end
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Response %0d mismatch:", checked);
					$display("  expected %p", want);
					$display("  actual   %p", got);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_ready;
	kspu_cmd_t cmd;
	logic rsp_valid;
	logic rsp_ready;
	kspu_rsp_t rsp;

	path_scoreboard board;
	int unsigned idle_cycles;
	bit calm;          // Set for the last part of the run: no random idling.
	bit hold_rsp;      // Requests a long receiver hold-off.
	int unsigned n_query, n_insert, n_remove, n_clear;
	// Frames used by the random part; a small pool makes replace and remove hit often.
	logic signed [31:0] frame_pool [$];

	keyframe_spline_path_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Note accepted commands, check responses as they are taken, and count idle cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				board.note_command(cmd);
			end
			if (rsp_valid && rsp_ready) begin
				board.check_response(rsp);
			end
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// Watchdog: nothing accepted on either channel for too long ends the run.
	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: random bursts of back-pressure, plus one long hold-off on request.
	initial begin
		int gap;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				for (int i = 0; i < 3000; i++) begin
					@(posedge clk);
				end
				hold_rsp = 1'b0;
				rsp_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 4);
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
				rsp_ready <= 1'b1;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Offer one command transaction and hold it until accepted.
	task automatic send_cmd(kspu_cmd_t c);
		if (!calm && $urandom_range(0, 4) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (!cmd_ready) begin
			@(posedge clk);
		end
		case (func_t'(c.func))
			FUNC_INSERT: n_insert++;
			FUNC_REMOVE: n_remove++;
			FUNC_QUERY: n_query++;
			default: n_clear++;
		endcase
	endtask

	function automatic kspu_cmd_t key_cmd(func_t f, logic signed [31:0] fr, bit ln,
			logic signed [31:0] v);
		kspu_cmd_t c;
		c = '{default: 0};
		c.func = f;
		c.frame = fr;
		c.linear = ln;
		{c.pos_x, c.pos_y, c.pos_z, c.ang_x, c.ang_y, c.ang_z, c.scl_x, c.scl_y, c.scl_z}
			= {9{v}};
		return c;
	endfunction

	function automatic logic signed [31:0] rand_chan();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
			default: return $signed($urandom_range(0, 2000000)) - 1000000;
		endcase
	endfunction

	function automatic kspu_cmd_t rand_cmd();
		kspu_cmd_t c;
		int sel;
		c = '{default: 0};
		{c.pos_x, c.pos_y, c.pos_z, c.ang_x, c.ang_y, c.ang_z, c.scl_x, c.scl_y, c.scl_z}
			= {rand_chan(), rand_chan(), rand_chan(), rand_chan(), rand_chan(),
			rand_chan(), rand_chan(), rand_chan(), rand_chan()};
		c.linear = ($urandom_range(0, 3) == 0);
		sel = $urandom_range(0, 99);
		if (sel < 40) begin
			c.func = FUNC_INSERT;
		end else if (sel < 52) begin
			c.func = FUNC_REMOVE;
		end else if (sel < 98) begin
			c.func = FUNC_QUERY;
		end else begin
			c.func = FUNC_CLEAR;
		end
		if ($urandom_range(0, 9) == 0) begin
			c.frame = $urandom();
		end else if (c.func == FUNC_QUERY) begin
			c.frame = $signed($urandom_range(0, 1100)) - 50;
		end else begin
			c.frame = frame_pool[$urandom_range(0, frame_pool.size() - 1)];
		end
		return c;
	endfunction

	initial begin
		board = new();
		idle_cycles = 0;
		calm = 1'b0;
		hold_rsp = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		arst_n = 1'b0;
		for (int i = 0; i < 64; i++) begin
			frame_pool.push_back(i * 16 + $urandom_range(0, 15));
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty-table query, single key, extremes, linear knots,
		// equal frames, removal of an absent frame, and clear.
		send_cmd(key_cmd(FUNC_QUERY, 5, 0, 0));
		send_cmd(key_cmd(FUNC_REMOVE, 7, 0, 0));
		send_cmd(key_cmd(FUNC_INSERT, 100, 1, 32'sh7fffffff));
		send_cmd(key_cmd(FUNC_QUERY, 32'sh80000000, 0, 0));
		send_cmd(key_cmd(FUNC_INSERT, 32'sh80000000, 0, 32'sh80000000));
		send_cmd(key_cmd(FUNC_INSERT, 32'sh7fffffff, 1, -32'sd65536));
		send_cmd(key_cmd(FUNC_INSERT, 0, 0, 32'sh00018000));
		send_cmd(key_cmd(FUNC_INSERT, 50, 0, 32'sh7fffffff));
		send_cmd(key_cmd(FUNC_QUERY, -3, 0, 0));
		send_cmd(key_cmd(FUNC_QUERY, 25, 0, 0));
		send_cmd(key_cmd(FUNC_QUERY, 75, 0, 0));
		send_cmd(key_cmd(FUNC_QUERY, 32'sh7fffffff, 0, 0));
		send_cmd(key_cmd(FUNC_INSERT, 50, 1, 32'sh80000000));
		send_cmd(key_cmd(FUNC_QUERY, 60, 0, 0));
		send_cmd(key_cmd(FUNC_REMOVE, 32'sh7fffffff, 0, 0));
		send_cmd(key_cmd(FUNC_QUERY, 1000, 0, 0));
		send_cmd(key_cmd(FUNC_REMOVE, 32'sh80000000, 0, 0));
		send_cmd(key_cmd(FUNC_CLEAR, 0, 0, 0));
		send_cmd(key_cmd(FUNC_QUERY, 0, 0, 0));
		send_cmd(key_cmd(FUNC_INSERT, 0, 0, 32'sh55555555));
		send_cmd(key_cmd(FUNC_INSERT, 0, 0, 32'shaaaaaaaa));
		send_cmd(key_cmd(FUNC_QUERY, 0, 0, 0));

		// Fill the table to capacity, then insert a new frame so it reports full, and replace an existing one.
		for (int i = 0; i < TBL_KEYS; i++) begin
			send_cmd(key_cmd(FUNC_INSERT, i * 8, i % 5 == 0, $urandom()));
			if (i == 20) begin
				hold_rsp = 1'b1;
			end
		end
		send_cmd(key_cmd(FUNC_INSERT, 3, 0, 1));
		send_cmd(key_cmd(FUNC_INSERT, 16, 0, 1));
		for (int i = 0; i < 20; i++) begin
			send_cmd(key_cmd(FUNC_QUERY, $urandom_range(0, 1100), 0, 0));
		end
		send_cmd(key_cmd(FUNC_CLEAR, 0, 0, 0));

		// Random part; the last stretch runs without idling.
		for (int i = 0; i < 480; i++) begin
			if (i == 410) begin
				calm = 1'b1;
			end
			send_cmd(rand_cmd());
		end
		cmd_valid <= 1'b0;

		while (board.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (600) @(posedge clk);

		$display("Covered %0d inserts, %0d removes, %0d queries and %0d clears,",
			n_insert, n_remove, n_query, n_clear);
		$display("including a full table and a long response hold-off; %0d responses checked.",
			board.checked);
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", board.mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
